// File: design/emkv_pkg.sv
// Shared types and constants for the exact-match key/value table.
`default_nettype none

package emkv_pkg;

  // Field widths of the stream words
  localparam int KEY_W     = 64;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 7;

  // Command codes carried on in_tuser
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Result status carried on out_tuser
  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

  // Probe word handed from cell to cell
  typedef struct packed {
    logic             live;
    cmd_t             cmd;
    logic             found;
    logic             claimed;
    logic [VAL_W-1:0] value;
  } probe_t;

  // Broadcast control from the controller to every cell
  typedef struct packed {
    logic settle;
    logic commit;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/exact_match_key_value_table.sv
// Top level of the exact-match key/value table: controller and cell chain.
//
// Input words (in_*): in_tuser holds the command (insert/update, erase, query,
// clear), in_tdata the 64-bit key and the 32-bit value for insert.
// Output words (out_*): one per input word; out_tuser holds the status (done or
// found, not found, table full), out_tdata the queried value, the entry count
// and the trie node count (2n-1, or 0 when empty).
// Each command walks a chain of CAPACITY slot cells, one cell per cycle, where
// it is compared, updated, erased or claims the first free slot; an insert of a
// new key is written into the claimed slot when the walk ends.
// One command is in flight at a time: a new word is taken only once the walk
// of the last one down the cell chain has ended and its result is registered.
// The output register lets the next command be accepted while the previous
// result still waits; a stalled receiver holds the result and the finished
// walk until out_tready rises.
// Reset (rst_n low, synchronous) empties the table at once; no clearing pass.
`default_nettype none

module exact_match_key_value_table
  import emkv_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,  // [63:0] key, [95:64] value_in
  input  wire logic [1:0]  in_tuser,  // [1:0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata, // [31:0] value_out, [38:32] entry_count,
                                      // [45:39] trie nodes, [47:46] zero
  output logic [1:0]       out_tuser  // [1:0] status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t             state_r, state_nxt;
  cmd_t               cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   val_r;
  logic               inject_r;
  probe_t             tail_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r;
  status_t            status_r, status_nxt;
  logic [VAL_W-1:0]   vout_r, vout_nxt;
  logic [CNT_OUT_W-1:0] entry_r, node_r;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
  logic [CNT_OUT_W-1:0] entry_nxt, node_nxt;
  logic               in_acc, out_free, fin_go;
  cell_ctl_t          ctl;
  probe_t             chain [CAPACITY+1];

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Head of the chain: the accepted command enters cell 0
  assign chain[0].live    = inject_r;
  assign chain[0].cmd     = cmd_r;
  assign chain[0].found   = 1'b0;
  assign chain[0].claimed = 1'b0;
  assign chain[0].value   = '0;

  // Slot cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    emkv_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .probe_i (chain[i]),
      .probe_o (chain[i+1]),
      .key_i   (key_r),
      .value_i (val_r),
      .ctl_i   (ctl)
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_WALK;
      S_WALK: if (chain[CAPACITY].live) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_tready  = 1'b0;
    fin_go     = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_WALK:  ;
      S_FIN:   fin_go = out_free;
      default: ;
    endcase
    ctl.settle = fin_go;
    ctl.commit = fin_go && (cmd_r == CMD_INSERT) && !tail_r.found && tail_r.claimed;
  end

  // Result of the finished walk
  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = STS_OK;
    vout_nxt   = '0;
    case (cmd_r)
      CMD_INSERT: begin
        if (!tail_r.found) begin
          if (tail_r.claimed) cnt_nxt = cnt_r + CNT_W'(1);
          else                status_nxt = STS_FULL;
        end
      end
      CMD_ERASE: begin
        if (tail_r.found) cnt_nxt = cnt_r - CNT_W'(1);
        else              status_nxt = STS_MISS;
      end
      CMD_QUERY: begin
        if (tail_r.found) vout_nxt = tail_r.value;
        else              status_nxt = STS_MISS;
      end
      default: cnt_nxt = '0;
    endcase
    cnt_ext   = {{CNT_OUT_W{1'b0}}, cnt_nxt};
    entry_nxt = cnt_ext[CNT_OUT_W-1:0];
    node_nxt  = (cnt_nxt == '0) ? '0
              : ({cnt_ext[CNT_OUT_W-2:0], 1'b0} - CNT_OUT_W'(1));
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inject_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      inject_r <= in_acc;
      if (fin_go) cnt_r <= cnt_nxt;
      if (fin_go)          out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Command, walk result and output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= cmd_t'(in_tuser);
      key_r <= in_tdata[KEY_W-1:0];
      val_r <= in_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (state_r == S_WALK && chain[CAPACITY].live) tail_r <= chain[CAPACITY];
    if (fin_go) begin
      status_r <= status_nxt;
      vout_r   <= vout_nxt;
      entry_r  <= entry_nxt;
      node_r   <= node_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, node_r, entry_r, vout_r};
  assign out_tuser  = status_r;

endmodule

`default_nettype wire

// File: design/emkv_cell.sv
// One slot of the table: key, value, valid flag and a link in the probe chain.
`default_nettype none

module emkv_cell
  import emkv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire probe_t           probe_i,
  output probe_t                probe_o,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic [VAL_W-1:0] value_i,
  input  wire cell_ctl_t        ctl_i
);

  logic             valid_r, valid_nxt;
  logic             claim_r, claim_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  probe_t           probe_r, probe_nxt;
  logic             hit;

  assign hit = probe_i.live && valid_r && (key_r == key_i);

  // Act on the passing probe word, or settle a pending claim
  always_comb begin
    probe_nxt = probe_i;
    valid_nxt = valid_r;
    claim_nxt = claim_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctl_i.settle) begin
      claim_nxt = 1'b0;
      if (ctl_i.commit && claim_r) begin
        valid_nxt = 1'b1;
        key_nxt   = key_i;
        value_nxt = value_i;
      end
    end
    if (probe_i.live) begin
      case (probe_i.cmd)
        CMD_INSERT: begin
          if (hit) begin
            value_nxt       = value_i;
            probe_nxt.found = 1'b1;
          end else if (!valid_r && !probe_i.found && !probe_i.claimed) begin
            // first free slot reserves itself until the walk ends
            claim_nxt         = 1'b1;
            probe_nxt.claimed = 1'b1;
          end
        end
        CMD_ERASE: begin
          if (hit) begin
            valid_nxt       = 1'b0;
            probe_nxt.found = 1'b1;
          end
        end
        CMD_QUERY: begin
          if (hit) begin
            probe_nxt.value = value_r;
            probe_nxt.found = 1'b1;
          end
        end
        default: begin
          valid_nxt = 1'b0;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      claim_r <= 1'b0;
      probe_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      claim_r <= claim_nxt;
      probe_r <= probe_nxt;
    end
  end

  // Slot payload
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign probe_o = probe_r;

endmodule

`default_nettype wire

// File: design/emkv_checker.sv
// Port-level checks for the key/value table, bound to its top level.
`default_nettype none

module emkv_checker
  import emkv_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // A stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // One command at a time: no acceptance right after one
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while one is in flight");

  // Node count follows entry count
  a_nodes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ((out_tdata[38:32] == 7'd0) && (out_tdata[45:39] == 7'd0)) ||
      ((out_tdata[38:32] != 7'd0) &&
       ((out_tdata[45:39] + 7'd1) == {out_tdata[37:32], 1'b0})))
    else $error("node count does not match entry count");

  // Value only on success, and never an undefined status
  a_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STS_OK) |->
      (out_tdata[31:0] == 32'd0) && (out_tuser != 2'd3))
    else $error("value or status wrong on a failed command");

endmodule

bind exact_match_key_value_table emkv_checker u_emkv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
